FILE: hw/rtl/mst_pkg.sv
`default_nettype none
package mst_pkg;
  localparam int unsigned SLOTS_DEF = 16;
  localparam logic [35:0] TICKS_PER_SECOND_DEF = 36'd1000000;

  localparam logic [1:0] MODE_RUN   = 2'd0;
  localparam logic [1:0] MODE_SLEEP = 2'd1;
  localparam logic [1:0] MODE_PAUSE = 2'd2;
  localparam logic [1:0] MODE_DONE  = 2'd3;

  localparam logic [2:0] EV_FIRED    = 3'd0;
  localparam logic [2:0] EV_TICK     = 3'd1;
  localparam logic [2:0] EV_CREATED  = 3'd2;
  localparam logic [2:0] EV_OK       = 3'd3;
  localparam logic [2:0] EV_NOTFOUND = 3'd4;
  localparam logic [2:0] EV_FULL     = 3'd5;
  localparam logic [2:0] EV_VALUE    = 3'd6;

  localparam logic [2:0] K_TICK    = 3'd0;
  localparam logic [2:0] K_CREATE  = 3'd1;
  localparam logic [2:0] K_PAUSE   = 3'd2;
  localparam logic [2:0] K_UNPAUSE = 3'd3;
  localparam logic [2:0] K_SLEEP   = 3'd4;
  localparam logic [2:0] K_STOP    = 3'd5;
  localparam logic [2:0] K_LEFT    = 3'd6;
  localparam logic [2:0] K_WORK    = 3'd7;

  typedef struct packed {
    logic [35:0] period;
    logic [36:0] elapsed;
    logic [16:0] repeats;
    logic [35:0] sleep_left;
    logic [15:0] ident;
  } slot_t;

  typedef struct packed {
    logic        fire;
    logic [1:0]  mode;
    logic        free_slot;
  } upd_t;
endpackage
`default_nettype wire

FILE: hw/rtl/mst_ram.sv
`default_nettype none
module mst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata <= mem_r[raddr];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/mst_slot_unit.sv
`default_nettype none
module mst_slot_unit (
  input  wire logic [1:0]          mode,
  input  wire mst_pkg::slot_t      cur,
  input  wire logic [35:0]         delta,
  output mst_pkg::slot_t           nxt,
  output mst_pkg::upd_t            upd
);
  logic [37:0] sum;
  logic [36:0] el;
  logic [16:0] rep;
  always_comb begin
    nxt = cur;
    upd = '0;
    upd.mode = mode;
    sum = {1'b0, cur.elapsed} + {2'b0, delta};
    el = sum[37] ? {37{1'b1}} : sum[36:0];
    rep = cur.repeats;
    case (mode)
      mst_pkg::MODE_RUN: begin
        nxt.elapsed = el;
        if (el >= {1'b0, cur.period}) begin
          upd.fire = 1'b1;
          nxt.elapsed = el - {1'b0, cur.period};
          if (!rep[16] && rep != '0) rep = rep - 17'd1;
          nxt.repeats = rep;
          if (rep == '0) upd.mode = mst_pkg::MODE_DONE;
        end
      end
      mst_pkg::MODE_SLEEP: begin
        if (cur.sleep_left <= delta) begin
          nxt.sleep_left = '0;
          upd.mode = mst_pkg::MODE_RUN;
        end else begin
          nxt.sleep_left = cur.sleep_left - delta;
        end
      end
      mst_pkg::MODE_PAUSE: ;
      default: begin
        upd.free_slot = 1'b1;
        upd.mode = mst_pkg::MODE_RUN;
      end
    endcase
  end
endmodule
`default_nettype wire

FILE: hw/rtl/multi_slot_repeating_timer.sv
`default_nettype none
// multi-slot repeating timer
// in_ channel: one command word (kind plus operands) per handshake
// out_ channel: result words; a tick gives one fired word per firing slot in
// slot order, then a tick done word; every other command gives one word;
// out_last marks the final word of a command
// cfg_ channel: writes max_tick_step, taken only while idle
// create and working time answer in the cycle after acceptance
// tick and lookups walk the slot table through a single slot update unit
// and a registered-read slot ram, each slot passing a read state and then
// an update state; a lookup stops at the slot that it hits
// the next command is taken the cycle after the final word leaves
// when out_ready is low the walk holds at the next firing slot, or at the
// end, until the pending word is taken
// reset frees all slots, zeroes the id counter and working time and sets
// max_tick_step to one second; no clearing pass is needed
module multi_slot_repeating_timer #(
  parameter int unsigned SLOTS = mst_pkg::SLOTS_DEF,
  parameter logic [35:0] TICKS_PER_SECOND = mst_pkg::TICKS_PER_SECOND_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_kind,
  input  wire logic [35:0]        in_elapsed_ticks,
  input  wire logic [15:0]        in_timer_id,
  input  wire logic [35:0]        in_duration,
  input  wire logic               in_delay_first,
  input  wire logic signed [16:0] in_repeat_count,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_event_kind,
  output logic [15:0]             out_fired_id,
  output logic signed [48:0]      out_reading,
  output logic                    out_last,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [35:0]        cfg_max_tick_step
);
  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned RD = 1 << AW;
  localparam logic [AW:0] LASTIX = (AW+1)'(SLOTS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_WK   = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]  st_r, st_nxt;
  logic [AW-1:0] ix_r, ix_nxt;
  logic [35:0] step_r;
  logic [SLOTS-1:0] used_r;
  logic [1:0]  mode_r [SLOTS];
  logic [15:0] nid_r;
  logic [47:0] total_r;
  logic [2:0]  kind_r;
  logic [15:0] id_r;
  logic [35:0] dur_r;
  logic [35:0] delta_r;
  logic        found_r;

  logic        ov_r, ov_nxt;
  logic [2:0]  oev_r;
  logic [15:0] oid_r;
  logic [48:0] ord_r;
  logic        olast_r;

  logic        we;
  logic [AW-1:0] waddr;
  mst_pkg::slot_t wdata, rdata, unxt;
  mst_pkg::upd_t  upd;
  logic [AW-1:0] raddr;

  mst_ram #(.WIDTH($bits(mst_pkg::slot_t)), .DEPTH(RD)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  mst_slot_unit u_unit (
    .mode(mode_r[ix_r]), .cur(rdata), .delta(delta_r), .nxt(unxt), .upd(upd)
  );

  logic out_free;
  logic [48:0] total_sum;
  logic [36:0] cre_el;
  logic [AW-1:0] free_ix;
  logic          any_free;

  assign out_free  = !ov_r || out_ready;
  assign in_ready  = (st_r == S_IDLE) && !ov_r;
  assign cfg_ready = (st_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_event_kind = oev_r;
  assign out_fired_id   = oid_r;
  assign out_reading    = ord_r;
  assign out_last       = olast_r;
  assign raddr = (st_r == S_IDLE) ? '0 : ix_r;
  assign total_sum = {1'b0, total_r} + {13'd0, in_elapsed_ticks};
  assign cre_el = in_delay_first ? 37'd0 : {1'b0, in_duration};

  always_comb begin
    free_ix = '0;
    any_free = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_ix = AW'(i);
        any_free = 1'b1;
      end
    end
  end

  logic match;
  assign match = used_r[ix_r] && rdata.ident == id_r;

  always_comb begin
    st_nxt = st_r;
    ix_nxt = ix_r;
    ov_nxt = ov_r && !out_ready;
    we = 1'b0;
    waddr = ix_r;
    wdata = unxt;
    case (st_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_kind == mst_pkg::K_CREATE) begin
            ov_nxt = 1'b1;
            we = any_free;
            waddr = free_ix;
            wdata.period = in_duration;
            wdata.elapsed = cre_el;
            wdata.repeats = in_repeat_count;
            wdata.sleep_left = '0;
            wdata.ident = nid_r;
          end else if (in_kind == mst_pkg::K_WORK) begin
            ov_nxt = 1'b1;
          end else begin
            st_nxt = S_RD;
            ix_nxt = '0;
          end
        end
      end
      S_RD: st_nxt = S_WK;
      S_WK: begin
        if (kind_r == mst_pkg::K_TICK) begin
          if (out_free || !(used_r[ix_r] && upd.fire)) begin
            we = used_r[ix_r];
            if (used_r[ix_r] && upd.fire) ov_nxt = 1'b1;
            if ({1'b0, ix_r} == LASTIX) st_nxt = S_FIN;
            else begin
              ix_nxt = ix_r + 1'b1;
              st_nxt = S_RD;
            end
          end
        end else begin
          if (found_r || {1'b0, ix_r} == LASTIX || match) st_nxt = S_FIN;
          else begin
            ix_nxt = ix_r + 1'b1;
            st_nxt = S_RD;
          end
          if (!found_r && match) begin
            ix_nxt = ix_r;
            if (kind_r == mst_pkg::K_SLEEP) begin
              we = 1'b1;
              wdata = rdata;
              wdata.sleep_left = dur_r;
            end
          end
        end
      end
      default: begin
        if (out_free) begin
          st_nxt = S_IDLE;
          ov_nxt = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ix_r <= '0;
      step_r <= TICKS_PER_SECOND;
      used_r <= '0;
      for (int i = 0; i < SLOTS; i++) mode_r[i] <= mst_pkg::MODE_RUN;
      nid_r <= '0;
      total_r <= '0;
      ov_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ix_r <= ix_nxt;
      ov_r <= ov_nxt;
      if (cfg_valid && cfg_ready) step_r <= cfg_max_tick_step;
      case (st_r)
        S_IDLE: begin
          found_r <= 1'b0;
          if (in_valid && in_ready) begin
            kind_r <= in_kind;
            id_r <= in_timer_id;
            dur_r <= in_duration;
            delta_r <= (in_elapsed_ticks < step_r) ? in_elapsed_ticks : step_r;
            if (in_kind == mst_pkg::K_TICK)
              total_r <= total_sum[48] ? {48{1'b1}} : total_sum[47:0];
            if (in_kind == mst_pkg::K_CREATE) begin
              olast_r <= 1'b1;
              ord_r <= '0;
              if (any_free) begin
                used_r[free_ix] <= 1'b1;
                mode_r[free_ix] <= mst_pkg::MODE_RUN;
                nid_r <= nid_r + 16'd1;
                oev_r <= mst_pkg::EV_CREATED;
                oid_r <= nid_r;
              end else begin
                oev_r <= mst_pkg::EV_FULL;
                oid_r <= '0;
              end
            end else if (in_kind == mst_pkg::K_WORK) begin
              olast_r <= 1'b1;
              oev_r <= mst_pkg::EV_VALUE;
              oid_r <= '0;
              ord_r <= {1'b0, total_r};
            end
          end
        end
        S_WK: begin
          if (kind_r == mst_pkg::K_TICK) begin
            if (used_r[ix_r] && (out_free || !upd.fire)) begin
              mode_r[ix_r] <= upd.mode;
              if (upd.free_slot) used_r[ix_r] <= 1'b0;
              if (upd.fire) begin
                oev_r <= mst_pkg::EV_FIRED;
                oid_r <= rdata.ident;
                ord_r <= '0;
                olast_r <= 1'b0;
              end
            end
          end else if (!found_r && match) begin
            found_r <= 1'b1;
            case (kind_r)
              mst_pkg::K_PAUSE:   mode_r[ix_r] <= mst_pkg::MODE_PAUSE;
              mst_pkg::K_UNPAUSE: mode_r[ix_r] <= mst_pkg::MODE_RUN;
              mst_pkg::K_SLEEP:   mode_r[ix_r] <= mst_pkg::MODE_SLEEP;
              mst_pkg::K_STOP:    mode_r[ix_r] <= mst_pkg::MODE_DONE;
              default: ord_r <= {13'd0, rdata.period} - {12'd0, rdata.elapsed};
            endcase
          end
        end
        S_FIN: begin
          if (out_free) begin
            olast_r <= 1'b1;
            oid_r <= '0;
            if (kind_r == mst_pkg::K_TICK) begin
              oev_r <= mst_pkg::EV_TICK;
              ord_r <= '0;
            end else if (!found_r) begin
              oev_r <= mst_pkg::EV_NOTFOUND;
              ord_r <= '0;
            end else if (kind_r == mst_pkg::K_LEFT) begin
              oev_r <= mst_pkg::EV_VALUE;
            end else begin
              oev_r <= mst_pkg::EV_OK;
              ord_r <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_kind))
    else $error("result word changed under stall");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != S_IDLE |-> !in_ready)
    else $error("accepted a command while busy");
  a_fire_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == mst_pkg::EV_FIRED |-> !out_last)
    else $error("fired word flagged last");
endmodule
`default_nettype wire
